// ===== rtl/olkd_pkg.sv =====
// Shared types and codes for the ordered key list.
package olkd_pkg;

   typedef enum logic [2:0] {
      OP_INSERT_FRONT = 3'd0,
      OP_DELETE_KEY   = 3'd1,
      OP_REMOVE_FRONT = 3'd2,
      OP_REMOVE_BACK  = 3'd3,
      OP_DUMP         = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_DUMP,
      S_RESP
   } state_type;

endpackage

// ===== rtl/olkd_ram.sv =====
// Synchronous single-port-write, single-port-read key store.
module olkd_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/ordered_list_with_key_delete.sv =====
// Top level of the ordered key list with delete by key.
// The keys live in a circular buffer in one synchronous memory, with a
// head pointer marking the front. Inserting at the front and removing at
// either end therefore only move a pointer. Delete by key reads the
// entries one per cycle from the front until a match, then closes the gap
// by moving each later entry one place towards the front, one entry per
// cycle. A dump emits one result transfer per entry at one per cycle
// while the output is not stalled, paced by the memory read port. The
// block takes one request at a time; results wait in an output register.
module ordered_list_with_key_delete #(
   parameter int CAPACITY  = 32,
   parameter int KEY_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // op[2:0], key[34:3], zero fill
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [39:0] rsp_tdata,   // status[1:0], out_key[33:2], count[39:34]
   output logic        rsp_tlast    // last
);
   import olkd_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;       // logical position being read
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [1:0] st_ff, st_in;
   logic rd_pend_ff, rd_pend_in;        // memory data valid this cycle

   logic rvalid_ff, rvalid_in;
   logic [1:0] rstatus_ff, rstatus_in;
   logic [31:0] rkey_ff, rkey_in;
   logic [CW-1:0] rcount_ff, rcount_in;
   logic rlast_ff, rlast_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [KEY_WIDTH-1:0] wr_data, rd_data;
   logic [KEY_WIDTH-1:0] req_key;
   logic [2:0] req_op;
   logic [5:0] rsp_count;
   logic out_free;

   olkd_ram #(.DEPTH(CAPACITY), .WIDTH(KEY_WIDTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   function automatic logic [AW-1:0] phys(logic [AW-1:0] h, logic [CW-1:0] p);
      logic [AW:0] s;
      s = {1'b0, h} + (AW+1)'(p);
      if (s >= (AW+1)'(CAPACITY)) s = s - (AW+1)'(CAPACITY);
      return s[AW-1:0];
   endfunction

   assign req_op = req_tdata[2:0];
   assign req_key = KEY_WIDTH'($signed(req_tdata[34:3]));
   assign out_free = !rvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign rsp_tvalid = rvalid_ff;
   // The count field is six bits wide whatever the capacity.
   assign rsp_count = 6'(rcount_ff);
   assign rsp_tdata = {rsp_count, rkey_ff, rstatus_ff};
   assign rsp_tlast = rlast_ff;
   assign rd_addr = phys(head_ff, pos_in);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               if ((req_op == OP_DELETE_KEY || req_op == OP_DUMP) && count_ff != '0)
                  state_in = (req_op == OP_DUMP) ? S_DUMP : S_SCAN;
               else
                  state_in = S_RESP;
            end
         end
         S_SCAN: begin
            if (rd_pend_ff && rd_data == key_ff)
               state_in = (pos_ff + CW'(1) >= count_ff) ? S_RESP : S_SHIFT;
            else if (rd_pend_ff && pos_ff + CW'(1) >= count_ff)
               state_in = S_RESP;
         end
         S_SHIFT: begin
            if (rd_pend_ff && pos_ff + CW'(1) >= count_ff) state_in = S_RESP;
         end
         S_DUMP: begin
            if (rd_pend_ff && out_free && pos_ff + CW'(1) >= count_ff)
               state_in = S_IDLE;
         end
         S_RESP: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in = head_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      key_in = key_ff;
      st_in = st_ff;
      rd_pend_in = 1'b0;
      wr_en = 1'b0;
      wr_addr = phys(head_ff, pos_ff);
      wr_data = rd_data;
      rvalid_in = rvalid_ff && !rsp_tready;
      rstatus_in = rstatus_ff;
      rkey_in = rkey_ff;
      rcount_in = rcount_ff;
      rlast_in = rlast_ff;
      case (state_ff)
         S_IDLE: begin
            pos_in = '0;
            if (req_tvalid && req_tready) begin
               key_in = req_key;
               st_in = ST_OK;
               rd_pend_in = 1'b1;
               case (req_op)
                  OP_INSERT_FRONT: begin
                     if (count_ff >= CW'(CAPACITY)) st_in = ST_FULL;
                     else begin
                        head_in = (head_ff == '0) ? AW'(CAPACITY - 1) : head_ff - AW'(1);
                        wr_en = 1'b1;
                        wr_addr = head_in;
                        wr_data = req_key;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_REMOVE_FRONT: begin
                     if (count_ff == '0) st_in = ST_MISS;
                     else begin
                        head_in = phys(head_ff, CW'(1));
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_REMOVE_BACK: begin
                     if (count_ff == '0) st_in = ST_MISS;
                     else count_in = count_ff - CW'(1);
                  end
                  OP_DELETE_KEY, OP_DUMP: begin
                     if (count_ff == '0) st_in = ST_MISS;
                  end
                  default: st_in = ST_MISS;
               endcase
            end
         end
         S_SCAN: begin
            if (rd_pend_ff) begin
               if (rd_data == key_ff) begin
                  if (pos_ff + CW'(1) >= count_ff) count_in = count_ff - CW'(1);
                  else begin
                     pos_in = pos_ff + CW'(1);
                     rd_pend_in = 1'b1;
                  end
               end else if (pos_ff + CW'(1) >= count_ff) st_in = ST_MISS;
               else begin
                  pos_in = pos_ff + CW'(1);
                  rd_pend_in = 1'b1;
               end
            end
         end
         S_SHIFT: begin
            // Entry at pos moves one place towards the front.
            if (rd_pend_ff) begin
               wr_en = 1'b1;
               wr_addr = phys(head_ff, pos_ff - CW'(1));
               if (pos_ff + CW'(1) >= count_ff) count_in = count_ff - CW'(1);
               else begin
                  pos_in = pos_ff + CW'(1);
                  rd_pend_in = 1'b1;
               end
            end
         end
         S_DUMP: begin
            rd_pend_in = rd_pend_ff;
            if (rd_pend_ff && out_free) begin
               rvalid_in = 1'b1;
               rstatus_in = ST_OK;
               // Low 32 bits of the stored key, zero filled when keys are narrower.
               rkey_in = 32'(rd_data);
               rcount_in = count_ff;
               rlast_in = (pos_ff + CW'(1) >= count_ff);
               if (!rlast_in) pos_in = pos_ff + CW'(1);
            end
         end
         S_RESP: begin
            if (out_free) begin
               rvalid_in = 1'b1;
               rstatus_in = st_ff;
               rkey_in = '0;
               rcount_in = count_ff;
               rlast_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0;
         count_ff <= '0;
         pos_ff <= '0;
         rd_pend_ff <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         count_ff <= count_in;
         pos_ff <= pos_in;
         rd_pend_ff <= rd_pend_in;
         rvalid_ff <= rvalid_in;
      end
      key_ff <= key_in;
      st_ff <= st_in;
      rstatus_ff <= rstatus_in;
      rkey_ff <= rkey_in;
      rcount_ff <= rcount_in;
      rlast_ff <= rlast_in;
   end
endmodule
